/* rtl/plist_pkg.sv */
// Shared types and constants for the positional list store.
// Holds opcodes, status codes, the cell command struct and the controller states.
// Depends on nothing.
package plist_pkg;

   // Operation codes carried in the request beat.
   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_INSERT_AT  = 3'd2;
   localparam logic [2:0] OP_POP_FRONT  = 3'd3;
   localparam logic [2:0] OP_POP_BACK   = 3'd4;
   localparam logic [2:0] OP_ERASE_AT   = 3'd5;
   localparam logic [2:0] OP_TRAVERSE   = 3'd6;

   // Status codes carried in the response beat.
   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_INVALID = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;

   // Index width that covers the largest supported list.
   localparam int IDX_MAX_BITS = 10;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_ERASE  = 2'd2,
      CELL_ROTATE = 2'd3
   } cell_mode_type;

   // Broadcast from the controller to every cell of the chain.
   typedef struct packed {
      cell_mode_type             mode;
      logic [IDX_MAX_BITS-1:0]   idx;
   } cell_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_TRAV = 2'b10
   } ctrl_state_type;

endpackage

/* rtl/plist_cell.sv */
// One storage cell of the list chain: holds a single word and picks its next
// value from itself, its neighbors, the head word or the new word.
// Depends on plist_pkg.
module plist_cell #(
   parameter int WORD_BITS  = 32,
   parameter int CELL_INDEX = 0
) (
   input  logic                  clock,
   input  plist_pkg::cell_cmd_type cmd,
   input  logic [WORD_BITS-1:0]  new_word,
   input  logic [WORD_BITS-1:0]  left_word,
   input  logic [WORD_BITS-1:0]  right_word,
   input  logic [WORD_BITS-1:0]  head_word,
   output logic [WORD_BITS-1:0]  word
);

   localparam int IMB = plist_pkg::IDX_MAX_BITS;
   localparam logic [IMB-1:0] MY_IDX = IMB'(CELL_INDEX);

   logic [WORD_BITS-1:0] word_ff;
   logic [WORD_BITS-1:0] word_in;

   always_comb begin
      word_in = word_ff;
      case (cmd.mode)
         plist_pkg::CELL_INSERT: begin
            if (MY_IDX > cmd.idx) begin
               word_in = left_word;
            end else if (MY_IDX == cmd.idx) begin
               word_in = new_word;
            end
         end
         plist_pkg::CELL_ERASE: begin
            if (MY_IDX >= cmd.idx) begin
               word_in = right_word;
            end
         end
         // The cell at the tail of the list receives the head; the rest move
         // one place toward the head.
         plist_pkg::CELL_ROTATE: begin
            if (MY_IDX == cmd.idx) begin
               word_in = head_word;
            end else begin
               word_in = right_word;
            end
         end
         default: begin
            word_in = word_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

/* rtl/positional_list_store_top.sv */
// Top level of the positional list store: controller, length register,
// response register and the chain of storage cells.
// Depends on plist_pkg and plist_cell.
//
//  channel | direction | ports
//  --------+-----------+-----------------------------------------------------
//  req     | in        | req_valid, req_ready, req_opcode, req_value, req_position
//  rsp     | out       | rsp_valid, rsp_ready, rsp_status, rsp_item_value,
//          |           | rsp_item_valid, rsp_last, rsp_length
//
// Every operation except traverse updates all cells at once and answers with a single beat.
// A traverse of n elements returns n beats, one per cycle unless stalled,
// by rotating the chain so that the head cell always holds the next element.
// Synchronous reset empties the list; cell contents are not cleared.
// A stalled response holds the chain and blocks new requests until it is taken.
module positional_list_store_top #(
   parameter int DEPTH     = 32,
   parameter int WORD_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [2:0]          req_opcode,
   input  logic signed [31:0]  req_value,
   input  logic [7:0]          req_position,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_status,
   output logic signed [31:0]  rsp_item_value,
   output logic                rsp_item_valid,
   output logic                rsp_last,
   output logic [5:0]          rsp_length
);

   localparam int IDX_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam int IMB      = plist_pkg::IDX_MAX_BITS;
   localparam int PW       = ((CNT_BITS > 8) ? CNT_BITS : 8) + 1;
   localparam int LW       = (CNT_BITS > 6) ? CNT_BITS : 6;
   localparam int VW       = (WORD_BITS > 32) ? WORD_BITS : 32;

   plist_pkg::ctrl_state_type state_ff, state_in;
   logic [CNT_BITS-1:0] length_ff, length_in;
   logic [CNT_BITS-1:0] trav_cnt_ff, trav_cnt_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic [31:0]         rsp_item_value_ff, rsp_item_value_in;
   logic                rsp_item_valid_ff, rsp_item_valid_in;
   logic                rsp_last_ff, rsp_last_in;
   logic [5:0]          rsp_length_ff, rsp_length_in;
   logic                rsp_load;

   plist_pkg::cell_cmd_type cmd;
   logic [WORD_BITS-1:0]    cell_word [DEPTH];
   logic [WORD_BITS-1:0]    new_word;
   logic signed [VW-1:0]    value_ext;
   logic [VW-1:0]           head_ext;

   logic                slot_free;
   logic                accept;
   logic                full;
   logic                empty;
   logic [PW-1:0]       pos_w;
   logic [PW-1:0]       len_w;
   logic                ins_ok;
   logic                erase_ok;
   logic [IDX_BITS-1:0] pos_idx;
   logic [IDX_BITS-1:0] tail_idx;
   logic [IDX_BITS-1:0] end_idx;
   logic [LW-1:0]       len_ext;
   logic                trav_last;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == plist_pkg::ST_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;

   assign full     = (length_ff == CNT_BITS'(DEPTH));
   assign empty    = (length_ff == '0);
   assign pos_w    = PW'(req_position);
   assign len_w    = PW'(length_ff);
   assign ins_ok   = (pos_w != '0) && (pos_w <= len_w + PW'(1));
   assign erase_ok = (pos_w != '0) && (pos_w <= len_w);
   assign pos_idx  = IDX_BITS'(pos_w - PW'(1));
   assign tail_idx = IDX_BITS'(length_ff - CNT_BITS'(1));
   assign end_idx  = IDX_BITS'(length_ff);
   assign trav_last = ((trav_cnt_ff + CNT_BITS'(1)) == length_ff);

   assign value_ext = VW'(req_value);
   assign new_word  = value_ext[WORD_BITS-1:0];
   assign head_ext  = VW'(cell_word[0]);
   assign len_ext   = LW'(length_in);

   always_comb begin
      state_in          = state_ff;
      length_in         = length_ff;
      trav_cnt_in       = trav_cnt_ff;
      cmd.mode          = plist_pkg::CELL_HOLD;
      cmd.idx           = '0;
      rsp_load          = 1'b0;
      rsp_status_in     = plist_pkg::STATUS_DONE;
      rsp_item_value_in = '0;
      rsp_item_valid_in = 1'b0;
      rsp_last_in       = 1'b1;
      case (state_ff)
         plist_pkg::ST_IDLE: begin
            if (accept) begin
               rsp_load = 1'b1;
               case (req_opcode)
                  plist_pkg::OP_PUSH_FRONT: begin
                     if (full) begin
                        rsp_status_in = plist_pkg::STATUS_FULL;
                     end else begin
                        cmd.mode  = plist_pkg::CELL_INSERT;
                        length_in = length_ff + CNT_BITS'(1);
                     end
                  end
                  plist_pkg::OP_PUSH_BACK: begin
                     if (full) begin
                        rsp_status_in = plist_pkg::STATUS_FULL;
                     end else begin
                        cmd.mode  = plist_pkg::CELL_INSERT;
                        cmd.idx   = IMB'(end_idx);
                        length_in = length_ff + CNT_BITS'(1);
                     end
                  end
                  plist_pkg::OP_INSERT_AT: begin
                     if (!ins_ok) begin
                        rsp_status_in = plist_pkg::STATUS_INVALID;
                     end else if (full) begin
                        rsp_status_in = plist_pkg::STATUS_FULL;
                     end else begin
                        cmd.mode  = plist_pkg::CELL_INSERT;
                        cmd.idx   = IMB'(pos_idx);
                        length_in = length_ff + CNT_BITS'(1);
                     end
                  end
                  plist_pkg::OP_POP_FRONT: begin
                     if (empty) begin
                        rsp_status_in = plist_pkg::STATUS_INVALID;
                     end else begin
                        cmd.mode  = plist_pkg::CELL_ERASE;
                        length_in = length_ff - CNT_BITS'(1);
                     end
                  end
                  plist_pkg::OP_POP_BACK: begin
                     if (empty) begin
                        rsp_status_in = plist_pkg::STATUS_INVALID;
                     end else begin
                        cmd.mode  = plist_pkg::CELL_ERASE;
                        cmd.idx   = IMB'(tail_idx);
                        length_in = length_ff - CNT_BITS'(1);
                     end
                  end
                  plist_pkg::OP_ERASE_AT: begin
                     if (!erase_ok) begin
                        rsp_status_in = plist_pkg::STATUS_INVALID;
                     end else begin
                        cmd.mode  = plist_pkg::CELL_ERASE;
                        cmd.idx   = IMB'(pos_idx);
                        length_in = length_ff - CNT_BITS'(1);
                     end
                  end
                  plist_pkg::OP_TRAVERSE: begin
                     // An empty list answers with a single marker beat.
                     if (!empty) begin
                        rsp_load    = 1'b0;
                        state_in    = plist_pkg::ST_TRAV;
                        trav_cnt_in = '0;
                     end
                  end
                  default: begin
                     rsp_status_in = plist_pkg::STATUS_INVALID;
                  end
               endcase
            end
         end
         plist_pkg::ST_TRAV: begin
            if (slot_free) begin
               rsp_load          = 1'b1;
               rsp_item_value_in = head_ext[31:0];
               rsp_item_valid_in = 1'b1;
               rsp_last_in       = trav_last;
               cmd.mode          = plist_pkg::CELL_ROTATE;
               cmd.idx           = IMB'(tail_idx);
               trav_cnt_in       = trav_cnt_ff + CNT_BITS'(1);
               if (trav_last) begin
                  state_in = plist_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = plist_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_length_in = len_ext[5:0];
   assign rsp_valid_in  = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= plist_pkg::ST_IDLE;
         length_ff    <= '0;
         trav_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         length_ff    <= length_in;
         trav_cnt_ff  <= trav_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff     <= rsp_status_in;
         rsp_item_value_ff <= rsp_item_value_in;
         rsp_item_valid_ff <= rsp_item_valid_in;
         rsp_last_ff       <= rsp_last_in;
         rsp_length_ff     <= rsp_length_in;
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         logic [WORD_BITS-1:0] left_word;
         logic [WORD_BITS-1:0] right_word;
         if (gi == 0) begin : g_first
            assign left_word = '0;
         end else begin : g_mid_left
            assign left_word = cell_word[gi-1];
         end
         if (gi == DEPTH - 1) begin : g_last
            assign right_word = cell_word[0];
         end else begin : g_mid_right
            assign right_word = cell_word[gi+1];
         end
         plist_cell #(
            .WORD_BITS  (WORD_BITS),
            .CELL_INDEX (gi)
         ) u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .new_word   (new_word),
            .left_word  (left_word),
            .right_word (right_word),
            .head_word  (cell_word[0]),
            .word       (cell_word[gi])
         );
      end
   endgenerate

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_item_value = rsp_item_value_ff;
   assign rsp_item_valid = rsp_item_valid_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_length     = rsp_length_ff;

endmodule
